FILE: src/tile_latched_bank_mapper_defines.svh
// Assertion macros for the tile latched bank mapper checker.
`ifndef TILE_LATCHED_BANK_MAPPER_DEFINES_SVH
`define TILE_LATCHED_BANK_MAPPER_DEFINES_SVH

// Checked only outside reset.
`define TLBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlbm assertion failed");

// Checked at every edge, reset included.
`define TLBM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tlbm assertion failed");

`endif

FILE: src/tlbm_pkg.sv
// Shared types and constants for the tile latched bank mapper.
`default_nettype none

package tlbm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int BANKS_W     = 9;
    localparam int PRG_W       = 4;
    localparam int CHR_W       = 5;
    localparam int SLOT_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PRG_BANKS_8K   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_VERTICAL = 2'd1;

    localparam logic [BANKS_W-1:0] PRG_BANKS_RESET = 9'd16;
    localparam logic [BANKS_W-1:0] PRG_BANKS_MIN   = 9'd4;
    localparam logic [BANKS_W-1:0] PRG_BANKS_MAX   = 9'd256;

    // Item operations
    localparam logic OP_CPU_WRITE = 1'b0;
    localparam logic OP_PPU_FETCH = 1'b1;

    // CPU write regions, address bits 15..12
    localparam logic [3:0] RGN_PRG_SELECT = 4'hA;
    localparam logic [3:0] RGN_CHR0       = 4'hB;
    localparam logic [3:0] RGN_CHR1       = 4'hC;
    localparam logic [3:0] RGN_CHR2       = 4'hD;
    localparam logic [3:0] RGN_CHR3       = 4'hE;
    localparam logic [3:0] RGN_MIRROR     = 4'hF;

    // PPU trigger tiles, address bits 7..4
    localparam logic [3:0] TILE_CLEAR = 4'hD;
    localparam logic [3:0] TILE_SET   = 4'hE;

    typedef enum logic {
        ST_IDLE,
        ST_REDUCE
    } state_t;

    typedef struct packed {
        logic apply;   // accept transaction and update mapper state
        logic step;    // subtract bank count from remainder
        logic load;    // load result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic rem_ge;  // remainder still >= bank count
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/tile_latched_bank_mapper.sv
// Top level of the tile latched bank mapper.
`default_nettype none

// Each accepted transaction (CPU register write or PPU pattern fetch) updates
// the mapper state at the accepting edge and yields one result: the four 8KB
// program slot banks, the two 4KB character banks picked by the tile latches,
// and the mirroring mode. The result is loaded into the output register once
// the remainder unit is done and the output register is free; the remainder
// unit takes the program bank select modulo the bank count by subtracting the
// count once per cycle, up to three times for counts of 4 and 5. A new
// transaction is taken in the cycle after the result is registered, while that
// result may still wait for out_ready. Configuration writes are always ready
// and take effect at the accepting edge, but a start-vertical write is lost if
// a transaction is accepted in the same cycle; write them only while the block
// holds no transaction.
module tile_latched_bank_mapper (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [tlbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [tlbm_pkg::BANKS_W-1:0]          cfg_data,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   op,
    input  wire  [15:0]                           address,
    input  wire  [7:0]                            data,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot0_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot1_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot2_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot3_bank,
    output logic [tlbm_pkg::CHR_W-1:0]            chr_low_bank,
    output logic [tlbm_pkg::CHR_W-1:0]            chr_high_bank,
    output logic                                  mirror_horizontal
);
    import tlbm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tlbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tlbm_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .op                (op),
        .address           (address),
        .data              (data),
        .cfg_write         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .prg_slot0_bank    (prg_slot0_bank),
        .prg_slot1_bank    (prg_slot1_bank),
        .prg_slot2_bank    (prg_slot2_bank),
        .prg_slot3_bank    (prg_slot3_bank),
        .chr_low_bank      (chr_low_bank),
        .chr_high_bank     (chr_high_bank),
        .mirror_horizontal (mirror_horizontal)
    );

endmodule

`default_nettype wire

FILE: src/tlbm_ctrl.sv
// Controller state machine for the tile latched bank mapper.
`default_nettype none

module tlbm_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire                     out_ready,
    input  tlbm_pkg::dp_status_t    status,
    output tlbm_pkg::ctrl_cmd_t     cmd
);
    import tlbm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (!status.rem_ge && out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.apply = 1'b0;
        cmd.step  = 1'b0;
        cmd.load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.apply = in_valid;
            end
            ST_REDUCE:
            begin
                cmd.step = status.rem_ge;
                cmd.load = !status.rem_ge && out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/tlbm_datapath.sv
// Datapath for the tile latched bank mapper: mapper state, remainder unit, result register.
`default_nettype none

module tlbm_datapath (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  tlbm_pkg::ctrl_cmd_t                   cmd,
    output tlbm_pkg::dp_status_t                  status,
    input  wire                                   op,
    input  wire  [15:0]                           address,
    input  wire  [7:0]                            data,
    input  wire                                   cfg_write,
    input  wire  [tlbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [tlbm_pkg::BANKS_W-1:0]          cfg_data,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot0_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot1_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot2_bank,
    output logic [tlbm_pkg::SLOT_W-1:0]           prg_slot3_bank,
    output logic [tlbm_pkg::CHR_W-1:0]            chr_low_bank,
    output logic [tlbm_pkg::CHR_W-1:0]            chr_high_bank,
    output logic                                  mirror_horizontal
);
    import tlbm_pkg::*;

    logic [BANKS_W-1:0] prg_banks_reg;
    logic [PRG_W-1:0]   prg_select_reg;
    logic [PRG_W-1:0]   prg_select_next;
    logic [CHR_W-1:0]   chr0_reg;
    logic [CHR_W-1:0]   chr0_next;
    logic [CHR_W-1:0]   chr1_reg;
    logic [CHR_W-1:0]   chr1_next;
    logic [CHR_W-1:0]   chr2_reg;
    logic [CHR_W-1:0]   chr2_next;
    logic [CHR_W-1:0]   chr3_reg;
    logic [CHR_W-1:0]   chr3_next;
    logic               latch_low_reg;
    logic               latch_low_next;
    logic               latch_high_reg;
    logic               latch_high_next;
    logic               mirror_reg;
    logic               mirror_next;
    logic [PRG_W-1:0]   rem_reg;
    logic [PRG_W-1:0]   rem_next;

    logic [BANKS_W-1:0] bank_n;
    logic               ppu_hit;

    logic [SLOT_W-1:0]  slot0_reg;
    logic [SLOT_W-1:0]  slot1_reg;
    logic [SLOT_W-1:0]  slot2_reg;
    logic [SLOT_W-1:0]  slot3_reg;
    logic [CHR_W-1:0]   chr_low_reg;
    logic [CHR_W-1:0]   chr_high_reg;
    logic               mirror_out_reg;

    // Bank count clamped to the supported range
    always_comb
    begin
        if (prg_banks_reg < PRG_BANKS_MIN)
            bank_n = PRG_BANKS_MIN;
        else if (prg_banks_reg > PRG_BANKS_MAX)
            bank_n = PRG_BANKS_MAX;
        else
            bank_n = prg_banks_reg;
    end

    // Pattern table fetch of tile FD or FE
    assign ppu_hit = (address[15:13] == 3'b000) && (address[11:8] == 4'hF) &&
                     ((address[7:4] == TILE_CLEAR) || (address[7:4] == TILE_SET));

    always_comb
    begin
        prg_select_next = prg_select_reg;
        chr0_next       = chr0_reg;
        chr1_next       = chr1_reg;
        chr2_next       = chr2_reg;
        chr3_next       = chr3_reg;
        latch_low_next  = latch_low_reg;
        latch_high_next = latch_high_reg;
        mirror_next     = mirror_reg;
        if (cmd.apply)
        begin
            if (op == OP_CPU_WRITE)
            begin
                unique case (address[15:12])
                    RGN_PRG_SELECT: prg_select_next = data[PRG_W-1:0];
                    RGN_CHR0:       chr0_next       = data[CHR_W-1:0];
                    RGN_CHR1:       chr1_next       = data[CHR_W-1:0];
                    RGN_CHR2:       chr2_next       = data[CHR_W-1:0];
                    RGN_CHR3:       chr3_next       = data[CHR_W-1:0];
                    RGN_MIRROR:     mirror_next     = data[0];
                    default: ;
                endcase
            end
            else if (ppu_hit)
            begin
                if (address[12])
                    latch_high_next = (address[7:4] == TILE_SET);
                else
                    latch_low_next = (address[7:4] == TILE_SET);
            end
        end
        else if (cfg_write && (cfg_index == REG_START_VERTICAL))
        begin
            mirror_next = !cfg_data[0];
        end
    end

    assign status.rem_ge = ({{(BANKS_W-PRG_W){1'b0}}, rem_reg} >= bank_n);

    // Remainder by repeated subtraction; only taken when bank count fits in PRG_W bits
    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.apply)
            rem_next = prg_select_next;
        else if (cmd.step)
            rem_next = rem_reg - bank_n[PRG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg      <= PRG_BANKS_RESET;
            prg_select_reg     <= '0;
            chr0_reg           <= '0;
            chr1_reg           <= '0;
            chr2_reg           <= '0;
            chr3_reg           <= '0;
            latch_low_reg      <= 1'b1;
            latch_high_reg     <= 1'b1;
            mirror_reg         <= 1'b1;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_PRG_BANKS_8K))
                prg_banks_reg <= cfg_data;
            prg_select_reg <= prg_select_next;
            chr0_reg       <= chr0_next;
            chr1_reg       <= chr1_next;
            chr2_reg       <= chr2_next;
            chr3_reg       <= chr3_next;
            latch_low_reg  <= latch_low_next;
            latch_high_reg <= latch_high_next;
            mirror_reg     <= mirror_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            slot0_reg      <= {{(SLOT_W-PRG_W){1'b0}}, rem_reg};
            slot1_reg      <= bank_n[SLOT_W-1:0] - SLOT_W'(3);
            slot2_reg      <= bank_n[SLOT_W-1:0] - SLOT_W'(2);
            slot3_reg      <= bank_n[SLOT_W-1:0] - SLOT_W'(1);
            chr_low_reg    <= latch_low_reg ? chr1_reg : chr0_reg;
            chr_high_reg   <= latch_high_reg ? chr3_reg : chr2_reg;
            mirror_out_reg <= mirror_reg;
        end
    end

    assign prg_slot0_bank    = slot0_reg;
    assign prg_slot1_bank    = slot1_reg;
    assign prg_slot2_bank    = slot2_reg;
    assign prg_slot3_bank    = slot3_reg;
    assign chr_low_bank      = chr_low_reg;
    assign chr_high_bank     = chr_high_reg;
    assign mirror_horizontal = mirror_out_reg;

endmodule

`default_nettype wire

FILE: src/tlbm_checker.sv
// Port-level assertion checker for the tile latched bank mapper, with its bind.
`default_nettype none

`include "tile_latched_bank_mapper_defines.svh"

module tlbm_checker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    input  wire                                   in_ready,
    input  wire                                   out_valid,
    input  wire                                   out_ready,
    input  wire  [tlbm_pkg::SLOT_W-1:0]           prg_slot0_bank,
    input  wire  [tlbm_pkg::SLOT_W-1:0]           prg_slot2_bank,
    input  wire  [tlbm_pkg::SLOT_W-1:0]           prg_slot3_bank
);

    // One transaction at a time: busy right after acceptance
    `TLBM_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

    // No result can be produced in the cycle after acceptance
    `TLBM_ASSERT(a_no_early_result, clk, rst_n, (in_valid && in_ready) |=> !$rose(out_valid))

    // Stalled result holds
    `TLBM_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(prg_slot0_bank)))

    // Top two fixed slots are consecutive banks
    `TLBM_ASSERT(a_fixed_slots, clk, rst_n, out_valid |-> (prg_slot3_bank == (prg_slot2_bank + 8'd1)))

    // Reset leaves no result pending
    `TLBM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind tile_latched_bank_mapper tlbm_checker u_tlbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prg_slot0_bank (prg_slot0_bank),
    .prg_slot2_bank (prg_slot2_bank),
    .prg_slot3_bank (prg_slot3_bank)
);

`default_nettype wire
